// File: src/mdda_pkg.sv
// ----------------------------------------------------------------------------
// mdda_pkg
// Shared types and constants for the multiply, divide, decimal adjust unit.
// ----------------------------------------------------------------------------
package mdda_pkg;

	typedef enum logic [2:0] {
		ACT_MUL = 3'd0,
		ACT_DIV = 3'd1,
		ACT_DAA = 3'd2,
		ACT_DAS = 3'd3,
		ACT_XCN = 3'd4
	} act_t;

	localparam int DIV_STEPS = 9;

	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [7:0] DAA_HI    = 8'h60;
	localparam logic [7:0] DAA_LO    = 8'h06;
	localparam logic [3:0] NIB_LIMIT = 4'h9;
	localparam logic [8:0] DIV_BASE  = 9'd256;
	localparam logic [7:0] BYTE_MAX  = 8'd255;
	localparam logic [7:0] SIGN_MASK = 8'h80;

	typedef struct packed {
		logic       is_div;
		logic       odd;
		logic [7:0] x;
		logic [7:0] a;
		logic [7:0] y;
		logic       c;
		logic       h;
		logic       v;
		logic       zn_y;
	} side_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [16:0] den;
		logic [8:0]  quo;
	} divw_t;

endpackage

// File: src/mdda_prep.sv
// ----------------------------------------------------------------------------
// mdda_prep
// First stage: decodes the action, does multiply, decimal adjust and swap,
// and sets up dividend and divisor for the divide steps.
// ----------------------------------------------------------------------------
module mdda_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2:0]      action,
	input  logic [7:0]      a_in,
	input  logic [7:0]      x_in,
	input  logic [7:0]      y_in,
	input  logic            carry_in,
	input  logic            half_in,
	input  logic            overflow_in,
	output logic            next_valid,
	output mdda_pkg::side_t next_side,
	output mdda_pkg::divw_t next_div
);
	import mdda_pkg::*;

	logic        valid_s1;
	side_t       side_s1;
	divw_t       div_s1;
	side_t       side_c;
	divw_t       div_c;
	act_t        act;
	logic [15:0] prod;
	logic [15:0] ya;
	logic [16:0] ya_off;
	logic [8:0]  dsor;
	logic [7:0]  adj;
	logic        adj_c;

	assign act    = act_t'(action);
	assign prod   = 16'(y_in) * 16'(a_in);
	assign ya     = {y_in, a_in};
	assign ya_off = {1'b0, ya} - {x_in, 9'b0};

	always_comb begin
		side_c.is_div = 1'b0;
		side_c.odd    = 1'b0;
		side_c.x      = x_in;
		side_c.a      = a_in;
		side_c.y      = y_in;
		side_c.c      = carry_in;
		side_c.h      = half_in;
		side_c.v      = overflow_in;
		side_c.zn_y   = 1'b0;
		div_c.rem     = '0;
		div_c.den     = '0;
		div_c.quo     = '0;
		adj           = a_in;
		adj_c         = carry_in;
		dsor          = '0;
		case (act)
			ACT_MUL: begin
				side_c.a    = prod[7:0];
				side_c.y    = prod[15:8];
				side_c.zn_y = 1'b1;
			end
			ACT_DIV: begin
				side_c.is_div = 1'b1;
				side_c.h      = (y_in[3:0] >= x_in[3:0]);
				side_c.v      = (y_in >= x_in);
				side_c.odd    = ({1'b0, y_in} >= {x_in, 1'b0});
				if (side_c.odd) begin
					div_c.rem = ya_off[15:0];
					dsor      = DIV_BASE - {1'b0, x_in};
				end else begin
					div_c.rem = ya;
					dsor      = {1'b0, x_in};
				end
				div_c.den = {dsor, 8'b0};
			end
			ACT_DAA: begin
				if (carry_in || a_in > DAA_LIMIT) begin
					adj   = a_in + DAA_HI;
					adj_c = 1'b1;
				end
				if (half_in || adj[3:0] > NIB_LIMIT)
					adj = adj + DAA_LO;
				side_c.a = adj;
				side_c.c = adj_c;
			end
			ACT_DAS: begin
				if (!carry_in || a_in > DAA_LIMIT) begin
					adj   = a_in - DAA_HI;
					adj_c = 1'b0;
				end
				if (!half_in || adj[3:0] > NIB_LIMIT)
					adj = adj - DAA_LO;
				side_c.a = adj;
				side_c.c = adj_c;
			end
			ACT_XCN: begin
				side_c.a = {a_in[3:0], a_in[7:4]};
			end
			default: begin
				side_c.a = a_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start;
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		div_s1  <= div_c;
	end

	assign next_valid = valid_s1;
	assign next_side  = side_s1;
	assign next_div   = div_s1;

endmodule

// File: src/mdda_div_step.sv
// ----------------------------------------------------------------------------
// mdda_div_step
// One restoring divide step per stage: trial subtract, keep or restore,
// shift one quotient bit in.
// ----------------------------------------------------------------------------
module mdda_div_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prev_valid,
	input  mdda_pkg::side_t prev_side,
	input  mdda_pkg::divw_t prev_div,
	output logic            next_valid,
	output mdda_pkg::side_t next_side,
	output mdda_pkg::divw_t next_div
);
	import mdda_pkg::*;

	logic        valid_sn;
	side_t       side_sn;
	divw_t       div_sn;
	logic [16:0] diff;
	logic        ge;

	assign ge   = ({1'b0, prev_div.rem} >= prev_div.den);
	assign diff = {1'b0, prev_div.rem} - prev_div.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sn <= 1'b0;
		else
			valid_sn <= prev_valid;
	end

	always_ff @(posedge clk) begin
		side_sn     <= prev_side;
		div_sn.rem  <= ge ? diff[15:0] : prev_div.rem;
		div_sn.den  <= prev_div.den >> 1;
		div_sn.quo  <= {prev_div.quo[7:0], ge};
	end

	assign next_valid = valid_sn;
	assign next_side  = side_sn;
	assign next_div   = div_sn;

	a_valid_follow: assert property (@(posedge clk) disable iff (!arst_n)
		next_valid == $past(prev_valid))
		else $error("divide step lost or invented an item");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(next_valid && next_side.is_div) |-> ({1'b0, next_div.rem} < $past(prev_div.den)))
		else $error("partial remainder not below shifted divisor");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(next_valid && next_side.is_div) |-> (next_div.rem <= $past(prev_div.rem)))
		else $error("partial remainder grew");

endmodule

// File: src/mdda_fin.sv
// ----------------------------------------------------------------------------
// mdda_fin
// Last stage: forms divide results, picks A and Y, derives zero and negative.
// ----------------------------------------------------------------------------
module mdda_fin (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prev_valid,
	input  mdda_pkg::side_t prev_side,
	input  mdda_pkg::divw_t prev_div,
	output logic            done,
	output logic [7:0]      a_out,
	output logic [7:0]      y_out,
	output logic            carry_out,
	output logic            half_out,
	output logic            overflow_out,
	output logic            zero_out,
	output logic            negative_out
);
	import mdda_pkg::*;

	logic       done_s11;
	logic [7:0] a_s11;
	logic [7:0] y_s11;
	logic       c_s11;
	logic       h_s11;
	logic       v_s11;
	logic       z_s11;
	logic       n_s11;
	logic [7:0] a_c;
	logic [7:0] y_c;
	logic [7:0] zn_c;

	always_comb begin
		a_c = prev_side.a;
		y_c = prev_side.y;
		if (prev_side.is_div) begin
			if (prev_side.odd) begin
				a_c = BYTE_MAX - prev_div.quo[7:0];
				y_c = prev_side.x + prev_div.rem[7:0];
			end else begin
				a_c = prev_div.quo[7:0];
				y_c = prev_div.rem[7:0];
			end
		end
		zn_c = prev_side.zn_y ? y_c : a_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s11 <= 1'b0;
		else
			done_s11 <= prev_valid;
	end

	always_ff @(posedge clk) begin
		a_s11 <= a_c;
		y_s11 <= y_c;
		c_s11 <= prev_side.c;
		h_s11 <= prev_side.h;
		v_s11 <= prev_side.v;
		z_s11 <= (zn_c == 8'd0);
		n_s11 <= ((zn_c & SIGN_MASK) != 8'd0);
	end

	assign done         = done_s11;
	assign a_out        = a_s11;
	assign y_out        = y_s11;
	assign carry_out    = c_s11;
	assign half_out     = h_s11;
	assign overflow_out = v_s11;
	assign zero_out     = z_s11;
	assign negative_out = n_s11;

endmodule

// File: src/mul_div_decimal_adjust_unit_top.sv
// ----------------------------------------------------------------------------
// mul_div_decimal_adjust_unit_top
// Multiply, divide, decimal adjust and nibble swap unit for an 8-bit core.
//
//   channel  handshake      payload
//   -------  -------------  ----------------------------------------------
//   command  start / busy   action, a_in, x_in, y_in, carry_in, half_in,
//                           overflow_in
//   result   done           a_out, y_out, carry_out, half_out,
//                           overflow_out, zero_out, negative_out
//
// One item per cycle; busy stays low. Every item passes from accept to
// done through one setup stage, nine restoring divide steps (one
// quotient bit each) and one result stage. All actions share the same latency.
// Reset clears the valid bits only. Results are never held off, so the
// pipeline advances every cycle.
// ----------------------------------------------------------------------------
module mul_div_decimal_adjust_unit_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [7:0] a_in,
	input  logic [7:0] x_in,
	input  logic [7:0] y_in,
	input  logic       carry_in,
	input  logic       half_in,
	input  logic       overflow_in,
	output logic       done,
	output logic [7:0] a_out,
	output logic [7:0] y_out,
	output logic       carry_out,
	output logic       half_out,
	output logic       overflow_out,
	output logic       zero_out,
	output logic       negative_out
);
	import mdda_pkg::*;

	logic  step_valid [0:DIV_STEPS];
	side_t step_side  [0:DIV_STEPS];
	divw_t step_div   [0:DIV_STEPS];

	assign busy = 1'b0;

	mdda_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.a_in        (a_in),
		.x_in        (x_in),
		.y_in        (y_in),
		.carry_in    (carry_in),
		.half_in     (half_in),
		.overflow_in (overflow_in),
		.next_valid  (step_valid[0]),
		.next_side   (step_side[0]),
		.next_div    (step_div[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		mdda_div_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (step_valid[i]),
			.prev_side  (step_side[i]),
			.prev_div   (step_div[i]),
			.next_valid (step_valid[i+1]),
			.next_side  (step_side[i+1]),
			.next_div   (step_div[i+1])
		);
	end

	mdda_fin u_fin (
		.clk          (clk),
		.arst_n       (arst_n),
		.prev_valid   (step_valid[DIV_STEPS]),
		.prev_side    (step_side[DIV_STEPS]),
		.prev_div     (step_div[DIV_STEPS]),
		.done         (done),
		.a_out        (a_out),
		.y_out        (y_out),
		.carry_out    (carry_out),
		.half_out     (half_out),
		.overflow_out (overflow_out),
		.zero_out     (zero_out),
		.negative_out (negative_out)
	);

endmodule

// File: tb/sv/mdda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdda_result_checker
// Watches the command and result channels of the multiply, divide, decimal
// adjust unit. Each accepted item is run through a local model of the unit.
// The expected result is queued and then compared with the next result the
// unit returns. The mismatch count and the number of results still owed go
// back to the testbench top.
// ----------------------------------------------------------------------------
module mdda_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] action,
	input  logic [7:0] a_in,
	input  logic [7:0] x_in,
	input  logic [7:0] y_in,
	input  logic       carry_in,
	input  logic       half_in,
	input  logic       overflow_in,
	input  logic       done,
	input  logic [7:0] a_out,
	input  logic [7:0] y_out,
	input  logic       carry_out,
	input  logic       half_out,
	input  logic       overflow_out,
	input  logic       zero_out,
	input  logic       negative_out,
	output int         mismatches,
	output int         pending
);
	import mdda_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] y;
		logic       c;
		logic       h;
		logic       v;
		logic       z;
		logic       n;
	} flags_res_t;

	flags_res_t expected_results[$];
	int         fail_count = 0;

	function automatic flags_res_t predict_result(logic [2:0] act, logic [7:0] a,
			logic [7:0] x, logic [7:0] y, logic c, logic h, logic v);
		flags_res_t  r;
		logic [7:0]  zn;
		logic [15:0] ya;
		int unsigned t;
		int unsigned d;
		r.a = a;
		r.y = y;
		r.c = c;
		r.h = h;
		r.v = v;
		ya  = {y, a};
		case (act)
			ACT_MUL: begin
				{r.y, r.a} = 16'(y) * 16'(a);
			end
			ACT_DIV: begin
				r.h = (y[3:0] >= x[3:0]);
				r.v = (y >= x);
				if ({1'b0, y} < {x, 1'b0}) begin
					r.a = 8'(ya / 16'(x));
					r.y = 8'(ya % 16'(x));
				end else begin
					t   = 32'(ya) - (32'(x) << 9);
					d   = 32'(DIV_BASE) - 32'(x);
					r.a = 8'(32'(BYTE_MAX) - t / d);
					r.y = 8'(32'(x) + t % d);
				end
			end
			ACT_DAA: begin
				if (c || r.a > DAA_LIMIT) begin
					r.a = r.a + DAA_HI;
					r.c = 1'b1;
				end
				if (h || r.a[3:0] > NIB_LIMIT)
					r.a = r.a + DAA_LO;
			end
			ACT_DAS: begin
				if (!c || r.a > DAA_LIMIT) begin
					r.a = r.a - DAA_HI;
					r.c = 1'b0;
				end
				if (!h || r.a[3:0] > NIB_LIMIT)
					r.a = r.a - DAA_LO;
			end
			ACT_XCN: begin
				r.a = {a[3:0], a[7:4]};
			end
			default: begin
			end
		endcase
		zn  = (act == ACT_MUL) ? r.y : r.a;
		r.z = (zn == 8'd0);
		r.n = |(zn & SIGN_MASK);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		flags_res_t got;
		flags_res_t want;
		if (!arst_n) begin
			expected_results.delete();
			fail_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (start && !busy)
				expected_results.push_back(predict_result(action, a_in, x_in, y_in,
					carry_in, half_in, overflow_in));
			if (done) begin
				got = {a_out, y_out, carry_out, half_out, overflow_out, zero_out,
					negative_out};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with no item pending: a=%h y=%h c%b h%b v%b z%b n%b",
							$realtime, got.a, got.y, got.c, got.h, got.v, got.z, got.n);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch exp a=%h y=%h c%b h%b v%b z%b n%b, got a=%h y=%h c%b h%b v%b z%b n%b",
								$realtime, want.a, want.y, want.c, want.h, want.v, want.z,
								want.n, got.a, got.y, got.c, got.h, got.v, got.z, got.n);
					end
				end
			end
			mismatches <= fail_count;
			pending    <= expected_results.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for mul_div_decimal_adjust_unit_top. A directed set covers the
// operand extremes, every action, both divide paths, a zero divisor and
// the decimal adjust corner cases. Random items follow, with idle bursts on
// the command side. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import mdda_pkg::*;

	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	localparam int         RANDOM_ITEMS = 950;
	localparam int         QUIET_TAIL   = 120;
	localparam int         TAIL_CYCLES  = 24;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] action;
	logic [7:0] a_in;
	logic [7:0] x_in;
	logic [7:0] y_in;
	logic       carry_in;
	logic       half_in;
	logic       overflow_in;
	logic       done;
	logic [7:0] a_out;
	logic [7:0] y_out;
	logic       carry_out;
	logic       half_out;
	logic       overflow_out;
	logic       zero_out;
	logic       negative_out;
	int         mismatches;
	int         pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mul_div_decimal_adjust_unit_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.a_in         (a_in),
		.x_in         (x_in),
		.y_in         (y_in),
		.carry_in     (carry_in),
		.half_in      (half_in),
		.overflow_in  (overflow_in),
		.done         (done),
		.a_out        (a_out),
		.y_out        (y_out),
		.carry_out    (carry_out),
		.half_out     (half_out),
		.overflow_out (overflow_out),
		.zero_out     (zero_out),
		.negative_out (negative_out)
	);

	mdda_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.a_in         (a_in),
		.x_in         (x_in),
		.y_in         (y_in),
		.carry_in     (carry_in),
		.half_in      (half_in),
		.overflow_in  (overflow_in),
		.done         (done),
		.a_out        (a_out),
		.y_out        (y_out),
		.carry_out    (carry_out),
		.half_out     (half_out),
		.overflow_out (overflow_out),
		.zero_out     (zero_out),
		.negative_out (negative_out),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	task automatic send_item(logic [2:0] act, logic [7:0] a, logic [7:0] x, logic [7:0] y,
			logic c, logic h, logic v);
		start       <= 1'b1;
		action      <= act;
		a_in        <= a;
		x_in        <= x;
		y_in        <= y;
		carry_in    <= c;
		half_in     <= h;
		overflow_in <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_for(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every owed result is back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if ($urandom_range(3, 0) == 0) begin
			case ($urandom_range(9, 0))
				0:       b = 8'h00;
				1:       b = 8'h01;
				2:       b = 8'h7F;
				3:       b = 8'h80;
				4:       b = 8'h99;
				5:       b = 8'h9A;
				6:       b = 8'h09;
				7:       b = 8'h0A;
				8:       b = 8'hFA;
				default: b = 8'hFF;
			endcase
		end
		return b;
	endfunction

	task automatic send_random_item();
		logic [2:0] act;
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		int         lim;
		if ($urandom_range(99, 0) < 3)
			act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		else
			act = 3'($urandom_range(ACT_MUL, ACT_XCN));
		a = pick_byte();
		x = pick_byte();
		y = pick_byte();
		if (act == ACT_DIV) begin
			case ($urandom_range(3, 0))
				0: x = 8'd0;
				1: begin
					if (x == 8'd0)
						x = 8'd1;
					lim = 2 * int'(x) - 1;
					if (lim > 255)
						lim = 255;
					y = 8'($urandom_range(lim, 0));
				end
				2: begin
					x = 8'($urandom_range(127, 0));
					y = 8'($urandom_range(255, 2 * int'(x)));
				end
				default: begin
				end
			endcase
		end
		send_item(act, a, x, y, 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	initial begin : stimulus
		bit quiet;
		start       <= 1'b0;
		action      <= ACT_MUL;
		a_in        <= 8'h00;
		x_in        <= 8'h00;
		y_in        <= 8'h00;
		carry_in    <= 1'b0;
		half_in     <= 1'b0;
		overflow_in <= 1'b0;
		arst_n      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ACT_MUL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(ACT_MUL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(ACT_MUL, 8'h01, 8'h00, 8'h80, 1'b0, 1'b1, 1'b0);
		send_item(ACT_DIV, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1);
		send_item(ACT_DIV, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DIV, 8'hFF, 8'hFF, 8'hFE, 1'b0, 1'b1, 1'b0);
		send_item(ACT_DIV, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1);
		send_item(ACT_DIV, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, 1'b1);
		send_item(ACT_DIV, 8'h34, 8'h10, 8'h20, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DIV, 8'h00, 8'h64, 8'hC8, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DIV, 8'hFF, 8'h80, 8'hFF, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DIV, 8'h55, 8'h0F, 8'h0E, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DAA, 8'h9A, 8'h00, 8'h12, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DAA, 8'h99, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DAA, 8'h0A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
		send_item(ACT_DAA, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
		send_item(ACT_DAS, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
		send_item(ACT_DAS, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(ACT_DAS, 8'h9A, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(ACT_DAS, 8'hFA, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
		send_item(ACT_XCN, 8'h0F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(ACT_XCN, 8'hF0, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(ACT_XCN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		send_item(ACT_SPARE_LO, 8'h80, 8'h11, 8'h22, 1'b1, 1'b0, 1'b1);
		send_item(ACT_SPARE_HI, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS - QUIET_TAIL) || ((i / 80) % 3 == 2);
			if (!quiet && $urandom_range(3, 0) == 0)
				idle_for($urandom_range(5, 1));
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			send_random_item();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
